>>> src/edpda_pkg.sv
// Shared types, constants, field arithmetic and the microcode program of the point unit.
`timescale 1ns / 1ps
package edpda_pkg;

    localparam logic [255:0] PRIME =
        256'h7FFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFED;
    localparam logic [255:0] BASE_YPX = {32'h07CF9D3A, 32'h33D4BA65, 32'h270B4898,
        32'h643D42C2, 32'hCF932DC6, 32'hFB8C0E19, 32'h2FBC93C6, 32'hF58C3B85};
    localparam logic [255:0] BASE_YMX = {32'h44FD2F92, 32'h98F81267, 32'hA5C18434,
        32'h688F8A09, 32'hFD399F05, 32'hD140BEB3, 32'h9D103905, 32'hD740913E};
    localparam logic [255:0] BASE_T2D = {32'h6F117B68, 32'h9F0C65A8, 32'h5A1B7DCB,
        32'hDD43598C, 32'h26D9E823, 32'hCCAAC49E, 32'hABC91205, 32'h877AAA68};

    localparam logic [2:0] OP_LOAD_P   = 3'd0;
    localparam logic [2:0] OP_LOAD_Q   = 3'd1;
    localparam logic [2:0] OP_DOUBLE   = 3'd2;
    localparam logic [2:0] OP_ADD_Q    = 3'd3;
    localparam logic [2:0] OP_ADD_BASE = 3'd4;

    localparam logic [1:0] COORD_BAD = 2'd3;

    localparam logic [3:0] R_X = 4'd0;
    localparam logic [3:0] R_Y = 4'd1;
    localparam logic [3:0] R_Z = 4'd2;
    localparam logic [3:0] R_T = 4'd3;
    localparam logic [3:0] R_YPX = 4'd4;
    localparam logic [3:0] R_YMX = 4'd5;
    localparam logic [3:0] R_T2D = 4'd6;
    localparam logic [3:0] R_T0 = 4'd7;
    localparam logic [3:0] R_T1 = 4'd8;
    localparam logic [3:0] R_T2 = 4'd9;
    localparam logic [3:0] R_T3 = 4'd10;
    localparam logic [3:0] R_T4 = 4'd11;
    localparam logic [3:0] R_T5 = 4'd12;
    localparam logic [3:0] R_T6 = 4'd13;
    localparam logic [3:0] R_T7 = 4'd14;
    localparam logic [3:0] R_ZERO = 4'd15;

    localparam logic [3:0] CO_YPX = 4'd0;
    localparam logic [3:0] CO_YMX = 4'd1;
    localparam logic [3:0] CO_T2D = 4'd2;
    localparam logic [3:0] CO_ZERO = 4'd3;

    localparam logic [5:0] ENT_DBL = 6'd0;
    localparam logic [5:0] ENT_ADDQ = 6'd20;
    localparam logic [5:0] ENT_BASE = 6'd24;
    localparam logic [5:0] ENT_COMMON = 6'd27;
    localparam logic [5:0] ENT_STORE = 6'd45;

    typedef enum logic [2:0] {U_CAN, U_ADD, U_SUB, U_MUL, U_STP, U_JMP, U_END} t_uop;
    typedef enum logic [1:0] {SRC_RF, SRC_P, SRC_Q, SRC_BASE} t_src;

    typedef struct packed {
        t_uop       uop;
        t_src       src;
        logic [3:0] dst;
        logic [3:0] ra;
        logic [3:0] rb;
        logic [5:0] tgt;
    } t_uword;

    typedef enum logic [1:0] {S_IDLE, S_FETCH, S_EXEC, S_MWAIT} t_seq_state;
    typedef enum logic [2:0] {M_IDLE, M_RUN, M_FLUSH, M_TOP, M_F1, M_F2, M_F3, M_CAN}
        t_mul_state;

    function automatic logic [254:0] fe_canon(input logic [255:0] v);
        logic [255:0] f;
        logic [256:0] d;
        f = {1'b0, v[254:0]} + (v[255] ? 256'd19 : 256'd0);
        d = {1'b0, f} - {1'b0, PRIME};
        fe_canon = d[256] ? f[254:0] : d[254:0];
    endfunction

    function automatic logic [254:0] fe_add(input logic [255:0] a, input logic [255:0] b);
        logic [256:0] s;
        logic [256:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, PRIME};
        fe_add = d[256] ? s[254:0] : d[254:0];
    endfunction

    function automatic logic [254:0] fe_sub(input logic [255:0] a, input logic [255:0] b);
        logic [256:0] d;
        logic [255:0] c;
        d = {1'b0, a} - {1'b0, b};
        c = d[255:0] + PRIME;
        fe_sub = d[256] ? c[254:0] : d[254:0];
    endfunction

    function automatic t_uword mk(input t_uop uop, input t_src src, input logic [3:0] dst,
                                  input logic [3:0] ra, input logic [3:0] rb,
                                  input logic [5:0] tgt);
        t_uword w;
        w.uop = uop;
        w.src = src;
        w.dst = dst;
        w.ra = ra;
        w.rb = rb;
        w.tgt = tgt;
        mk = w;
    endfunction

    function automatic t_uword rom_word(input logic [5:0] pc);
        t_uword w;
        w = mk(U_END, SRC_RF, R_X, R_X, R_X, ENT_DBL);
        case (pc)
            6'd0:  w = mk(U_CAN, SRC_BASE, R_ZERO, CO_ZERO, R_X, ENT_DBL);
            6'd1:  w = mk(U_CAN, SRC_P, R_X, R_X, R_X, ENT_DBL);
            6'd2:  w = mk(U_CAN, SRC_P, R_Y, R_Y, R_X, ENT_DBL);
            6'd3:  w = mk(U_CAN, SRC_P, R_Z, R_Z, R_X, ENT_DBL);
            6'd4:  w = mk(U_MUL, SRC_RF, R_T0, R_X, R_X, ENT_DBL);
            6'd5:  w = mk(U_MUL, SRC_RF, R_T1, R_Y, R_Y, ENT_DBL);
            6'd6:  w = mk(U_MUL, SRC_RF, R_T2, R_Z, R_Z, ENT_DBL);
            6'd7:  w = mk(U_ADD, SRC_RF, R_T2, R_T2, R_T2, ENT_DBL);
            6'd8:  w = mk(U_SUB, SRC_RF, R_T3, R_ZERO, R_T0, ENT_DBL);
            6'd9:  w = mk(U_SUB, SRC_RF, R_T4, R_T3, R_T1, ENT_DBL);
            6'd10: w = mk(U_ADD, SRC_RF, R_T5, R_T3, R_T1, ENT_DBL);
            6'd11: w = mk(U_SUB, SRC_RF, R_T6, R_T5, R_T2, ENT_DBL);
            6'd12: w = mk(U_ADD, SRC_RF, R_T7, R_X, R_Y, ENT_DBL);
            6'd13: w = mk(U_MUL, SRC_RF, R_T7, R_T7, R_T7, ENT_DBL);
            6'd14: w = mk(U_ADD, SRC_RF, R_T7, R_T7, R_T4, ENT_DBL);
            6'd15: w = mk(U_MUL, SRC_RF, R_X, R_T7, R_T6, ENT_DBL);
            6'd16: w = mk(U_MUL, SRC_RF, R_Y, R_T4, R_T5, ENT_DBL);
            6'd17: w = mk(U_MUL, SRC_RF, R_Z, R_T5, R_T6, ENT_DBL);
            6'd18: w = mk(U_MUL, SRC_RF, R_T, R_T7, R_T4, ENT_DBL);
            6'd19: w = mk(U_JMP, SRC_RF, R_X, R_X, R_X, ENT_STORE);
            6'd20: w = mk(U_CAN, SRC_Q, R_YPX, CO_YPX, R_X, ENT_DBL);
            6'd21: w = mk(U_CAN, SRC_Q, R_YMX, CO_YMX, R_X, ENT_DBL);
            6'd22: w = mk(U_CAN, SRC_Q, R_T2D, CO_T2D, R_X, ENT_DBL);
            6'd23: w = mk(U_JMP, SRC_RF, R_X, R_X, R_X, ENT_COMMON);
            6'd24: w = mk(U_CAN, SRC_BASE, R_YPX, CO_YPX, R_X, ENT_DBL);
            6'd25: w = mk(U_CAN, SRC_BASE, R_YMX, CO_YMX, R_X, ENT_DBL);
            6'd26: w = mk(U_CAN, SRC_BASE, R_T2D, CO_T2D, R_X, ENT_DBL);
            6'd27: w = mk(U_CAN, SRC_P, R_X, R_X, R_X, ENT_DBL);
            6'd28: w = mk(U_CAN, SRC_P, R_Y, R_Y, R_X, ENT_DBL);
            6'd29: w = mk(U_CAN, SRC_P, R_Z, R_Z, R_X, ENT_DBL);
            6'd30: w = mk(U_CAN, SRC_P, R_T, R_T, R_X, ENT_DBL);
            6'd31: w = mk(U_SUB, SRC_RF, R_T0, R_Y, R_X, ENT_DBL);
            6'd32: w = mk(U_MUL, SRC_RF, R_T0, R_T0, R_YMX, ENT_DBL);
            6'd33: w = mk(U_ADD, SRC_RF, R_T1, R_Y, R_X, ENT_DBL);
            6'd34: w = mk(U_MUL, SRC_RF, R_T1, R_T1, R_YPX, ENT_DBL);
            6'd35: w = mk(U_MUL, SRC_RF, R_T2, R_T, R_T2D, ENT_DBL);
            6'd36: w = mk(U_ADD, SRC_RF, R_T3, R_Z, R_Z, ENT_DBL);
            6'd37: w = mk(U_SUB, SRC_RF, R_T4, R_T1, R_T0, ENT_DBL);
            6'd38: w = mk(U_ADD, SRC_RF, R_T5, R_T1, R_T0, ENT_DBL);
            6'd39: w = mk(U_SUB, SRC_RF, R_T6, R_T3, R_T2, ENT_DBL);
            6'd40: w = mk(U_ADD, SRC_RF, R_T7, R_T3, R_T2, ENT_DBL);
            6'd41: w = mk(U_MUL, SRC_RF, R_X, R_T4, R_T6, ENT_DBL);
            6'd42: w = mk(U_MUL, SRC_RF, R_Y, R_T5, R_T7, ENT_DBL);
            6'd43: w = mk(U_MUL, SRC_RF, R_Z, R_T7, R_T6, ENT_DBL);
            6'd44: w = mk(U_MUL, SRC_RF, R_T, R_T4, R_T5, ENT_DBL);
            6'd45: w = mk(U_STP, SRC_RF, R_X, R_X, R_X, ENT_DBL);
            6'd46: w = mk(U_STP, SRC_RF, R_Y, R_Y, R_X, ENT_DBL);
            6'd47: w = mk(U_STP, SRC_RF, R_Z, R_Z, R_X, ENT_DBL);
            6'd48: w = mk(U_STP, SRC_RF, R_T, R_T, R_X, ENT_DBL);
            default: w = mk(U_END, SRC_RF, R_X, R_X, R_X, ENT_DBL);
        endcase
        rom_word = w;
    endfunction

endpackage

>>> src/edpda_mul.sv
// Modular multiplier over p = 2^255-19 built on one 32x32 multiplier, column by column.
`timescale 1ns / 1ps
module edpda_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [255:0] i_a,
    input  logic [255:0] i_b,
    output logic         o_done,
    output logic [254:0] o_p
);
    import edpda_pkg::*;

    t_mul_state   r_state;
    t_mul_state   n_state;
    logic [6:0]   r_idx;
    logic [31:0]  r_a [8];
    logic [31:0]  r_b [8];
    logic [31:0]  r_t [16];
    logic [63:0]  r_prod;
    logic         r_pv;
    logic         r_last;
    logic [3:0]   r_k;
    logic [71:0]  r_acc;
    logic [261:0] r_fold;
    logic [254:0] r_p;
    logic         r_done;

    logic [3:0]   w_k;
    logic [2:0]   w_i;
    logic [4:0]   w_diff;
    logic         w_ok;
    logic [71:0]  w_sum;
    logic [255:0] w_lo;
    logic [255:0] w_hi;

    assign w_k    = r_idx[6:3];
    assign w_i    = r_idx[2:0];
    assign w_diff = {1'b0, w_k} - {2'b00, w_i};
    assign w_ok   = (w_diff[4:3] == 2'b00);
    assign w_sum  = r_acc + {8'd0, r_prod};

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_lo[32*k +: 32] = r_t[k];
            w_hi[32*k +: 32] = r_t[k+8];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            M_IDLE:  if (i_start) n_state = M_RUN;
            M_RUN:   if (r_idx == 7'd119) n_state = M_FLUSH;
            M_FLUSH: n_state = M_TOP;
            M_TOP:   n_state = M_F1;
            M_F1:    n_state = M_F2;
            M_F2:    n_state = M_F3;
            M_F3:    n_state = M_CAN;
            M_CAN:   n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == M_CAN);
            r_pv    <= (r_state == M_RUN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == M_IDLE && i_start) begin
            for (int k = 0; k < 8; k++) begin
                r_a[k] <= i_a[32*k +: 32];
                r_b[k] <= i_b[32*k +: 32];
            end
            r_idx <= 7'd0;
            r_acc <= 72'd0;
        end
        if (r_state == M_RUN) begin
            r_idx  <= 7'(r_idx + 7'd1);
            r_prod <= w_ok ? (64'(r_a[w_i]) * 64'(r_b[w_diff[2:0]])) : 64'd0;
            r_last <= (w_i == 3'd7);
            r_k    <= w_k;
        end
        if (r_pv) begin
            if (r_last) begin
                r_t[r_k] <= w_sum[31:0];
                r_acc    <= {32'd0, w_sum[71:32]};
            end else begin
                r_acc <= w_sum;
            end
        end
        if (r_state == M_TOP) begin
            r_t[15] <= r_acc[31:0];
        end
        if (r_state == M_F1) begin
            r_fold <= {6'd0, w_lo} + ({6'd0, w_hi} << 5) + ({6'd0, w_hi} << 2)
                      + ({6'd0, w_hi} << 1);
        end
        if (r_state == M_F2) begin
            r_fold <= {6'd0, r_fold[255:0]} + 262'(r_fold[261:256]) * 262'd38;
        end
        if (r_state == M_F3) begin
            r_fold <= {6'd0, r_fold[255:0]} + (r_fold[256] ? 262'd38 : 262'd0);
        end
        if (r_state == M_CAN) begin
            r_p <= fe_canon(r_fold[255:0]);
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

>>> src/edwards_point_double_add.sv
// Top level: microcoded sequencer, field register file, point stores and result port.
// Loads and unused op codes answer in the cycle after acceptance.
// Double, add Q and add base point answer when their microcode program ends, each using the
// shared 32x32 multiplier for its products: eight products per double, seven per add.
// Busy stays high until the result strobe; the next item may start in the strobe cycle.
// Synchronous reset clears P and Q to zero and returns the sequencer to idle.
`timescale 1ns / 1ps
module edwards_point_double_add (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_op,
    input  logic [1:0]  i_coord,
    input  logic [1:0]  i_limb,
    input  logic [63:0] i_value,
    output logic        o_strobe,
    output logic [63:0] o_read_value,
    output logic        o_status
);
    import edpda_pkg::*;

    t_seq_state   r_state;
    t_seq_state   n_state;
    logic [5:0]   r_pc;
    logic [5:0]   n_pc;
    logic         r_strobe;
    logic         n_strobe;
    logic [3:0]   r_sel;
    logic [3:0]   n_sel;
    logic         r_status;
    logic         n_status;

    logic [63:0]  r_acc [16];
    logic [63:0]  r_opnd [12];
    logic [255:0] r_rf [16];
    logic [255:0] r_rd_a;
    logic [255:0] r_rd_b;

    t_uword       w_uw;
    logic         w_ld_p;
    logic         w_ld_q;
    logic         w_stp;
    logic         w_rf_we;
    logic [255:0] w_rf_wd;
    logic         w_mul_start;
    logic         w_mul_done;
    logic [254:0] w_mul_p;
    logic [255:0] w_src;
    logic [254:0] w_alu;
    logic [1:0]   w_c;

    assign w_uw = rom_word(r_pc);
    assign w_c  = w_uw.ra[1:0];

    always_comb begin
        w_src = 256'd0;
        case (w_uw.src)
            SRC_RF: w_src = r_rd_a;
            SRC_P: begin
                for (int k = 0; k < 4; k++) w_src[64*k +: 64] = r_acc[{w_c, 2'(k)}];
            end
            SRC_Q: begin
                if (w_c != COORD_BAD) begin
                    for (int k = 0; k < 4; k++) w_src[64*k +: 64] = r_opnd[{w_c, 2'(k)}];
                end
            end
            SRC_BASE: begin
                case (w_uw.ra)
                    CO_YPX:  w_src = BASE_YPX;
                    CO_YMX:  w_src = BASE_YMX;
                    CO_T2D:  w_src = BASE_T2D;
                    default: w_src = 256'd0;
                endcase
            end
            default: w_src = 256'd0;
        endcase
    end

    always_comb begin
        case (w_uw.uop)
            U_CAN:   w_alu = fe_canon(w_src);
            U_ADD:   w_alu = fe_add(r_rd_a, r_rd_b);
            U_SUB:   w_alu = fe_sub(r_rd_a, r_rd_b);
            default: w_alu = 255'd0;
        endcase
    end

    edpda_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (r_rd_a),
        .i_b     (r_rd_b),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_strobe    = 1'b0;
        n_sel       = r_sel;
        n_status    = r_status;
        w_ld_p      = 1'b0;
        w_ld_q      = 1'b0;
        w_stp       = 1'b0;
        w_rf_we     = 1'b0;
        w_rf_wd     = {1'b0, w_alu};
        w_mul_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_sel    = {i_coord, i_limb};
                    n_status = 1'b0;
                    case (i_op)
                        OP_LOAD_P: begin
                            w_ld_p   = 1'b1;
                            n_strobe = 1'b1;
                        end
                        OP_LOAD_Q: begin
                            if (i_coord == COORD_BAD) n_status = 1'b1;
                            else w_ld_q = 1'b1;
                            n_strobe = 1'b1;
                        end
                        OP_DOUBLE: begin
                            n_pc    = ENT_DBL;
                            n_state = S_FETCH;
                        end
                        OP_ADD_Q: begin
                            n_pc    = ENT_ADDQ;
                            n_state = S_FETCH;
                        end
                        OP_ADD_BASE: begin
                            n_pc    = ENT_BASE;
                            n_state = S_FETCH;
                        end
                        default: n_strobe = 1'b1;
                    endcase
                end
            end
            S_FETCH: n_state = S_EXEC;
            S_EXEC: begin
                case (w_uw.uop)
                    U_CAN, U_ADD, U_SUB: begin
                        w_rf_we = 1'b1;
                        n_pc    = 6'(r_pc + 6'd1);
                        n_state = S_FETCH;
                    end
                    U_MUL: begin
                        w_mul_start = 1'b1;
                        n_state     = S_MWAIT;
                    end
                    U_STP: begin
                        w_stp   = 1'b1;
                        n_pc    = 6'(r_pc + 6'd1);
                        n_state = S_FETCH;
                    end
                    U_JMP: begin
                        n_pc    = w_uw.tgt;
                        n_state = S_FETCH;
                    end
                    default: begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                endcase
            end
            S_MWAIT: begin
                if (w_mul_done) begin
                    w_rf_we = 1'b1;
                    w_rf_wd = {1'b0, w_mul_p};
                    n_pc    = 6'(r_pc + 6'd1);
                    n_state = S_FETCH;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= ENT_DBL;
            r_strobe <= 1'b0;
            r_sel    <= 4'd0;
            r_status <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_strobe <= n_strobe;
            r_sel    <= n_sel;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) r_acc[k] <= 64'd0;
            for (int k = 0; k < 12; k++) r_opnd[k] <= 64'd0;
        end else begin
            if (w_ld_p) r_acc[{i_coord, i_limb}] <= i_value;
            if (w_ld_q) r_opnd[{i_coord, i_limb}] <= i_value;
            if (w_stp) begin
                for (int k = 0; k < 4; k++) r_acc[{w_uw.dst[1:0], 2'(k)}] <= r_rd_a[64*k +: 64];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rf_we) r_rf[w_uw.dst] <= w_rf_wd;
        r_rd_a <= r_rf[w_uw.ra];
        r_rd_b <= r_rf[w_uw.rb];
    end

    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_read_value = r_acc[r_sel];
    assign o_status     = r_status;

`ifndef NO_ASSERTIONS
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_state == S_IDLE))
        else $error("result strobe while the sequencer is running");
    a_mul_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_start |=> (r_state == S_MWAIT))
        else $error("multiplier started without waiting for it");
    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_MWAIT))
        else $error("multiplier result with no product pending");
    a_load_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == OP_LOAD_P) |=> r_strobe)
        else $error("load item gave no result in the next cycle");
`endif

endmodule
